FILE: src/msa_pkg.sv
// Package for the mesh surface area unit: queue depth and back-part state type.
// No dependencies.
`timescale 1ns / 1ps

package msa_pkg;

    localparam int QUEUE_DEPTH = 2;

    // back part: take, square, root steps, accumulate
    typedef enum logic [1:0]
    {
        BK_IDLE,
        BK_SQ,
        BK_ROOT,
        BK_ACC
    } back_state_t;

endpackage

FILE: src/msa_front.sv
// Front part: accepts triangle beats, forms edge differences and the three
// plane determinants over two register stages. Depends on nothing else.
`timescale 1ns / 1ps

module msa_front #(
    parameter int COORD_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [9*COORD_BITS-1:0]   in_coords,
    input  logic                      in_last,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [2*COORD_BITS+1:0]   out_d1,
    output logic [2*COORD_BITS+1:0]   out_d2,
    output logic [2*COORD_BITS+1:0]   out_d3,
    output logic                      out_last
);
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int AW = 2 * COORD_BITS + 2;

    logic signed [COORD_BITS-1:0] c [9];
    logic signed [DW-1:0] e_next [6];
    logic signed [DW-1:0] e_reg  [6];
    logic                 s1_valid_reg;
    logic                 s1_last_reg;
    logic signed [PW:0]   p1, p2, p3;
    logic                 s1_adv;
    logic                 out_valid_reg;
    logic [AW-1:0]        d1_reg, d2_reg, d3_reg;
    logic                 out_last_reg;

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            c[i] = in_coords[i*COORD_BITS +: COORD_BITS];
        end
        // edges b-a and c-a for x, y, z
        for (int k = 0; k < 3; k++)
        begin
            e_next[k]   = DW'(c[3+k]) - DW'(c[k]);
            e_next[3+k] = DW'(c[6+k]) - DW'(c[k]);
        end
    end

    assign s1_adv   = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s1_adv;

    assign out_valid = out_valid_reg;
    assign out_d1    = d1_reg;
    assign out_d2    = d2_reg;
    assign out_d3    = d3_reg;
    assign out_last  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // xy, yz, zx determinants
    assign p1 = (PW+1)'(e_reg[0]) * (PW+1)'(e_reg[4])
              - (PW+1)'(e_reg[1]) * (PW+1)'(e_reg[3]);
    assign p2 = (PW+1)'(e_reg[1]) * (PW+1)'(e_reg[5])
              - (PW+1)'(e_reg[2]) * (PW+1)'(e_reg[4]);
    assign p3 = (PW+1)'(e_reg[2]) * (PW+1)'(e_reg[3])
              - (PW+1)'(e_reg[0]) * (PW+1)'(e_reg[5]);

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            e_reg       <= e_next;
            s1_last_reg <= in_last;
        end
        if (s1_adv && s1_valid_reg)
        begin
            d1_reg       <= AW'(p1[PW] ? -p1 : p1);
            d2_reg       <= AW'(p2[PW] ? -p2 : p2);
            d3_reg       <= AW'(p3[PW] ? -p3 : p3);
            out_last_reg <= s1_last_reg;
        end
    end

endmodule

FILE: src/msa_queue.sv
// Short queue between front and back parts, holding determinant entries.
// Depends on msa_pkg.
`timescale 1ns / 1ps

module msa_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    localparam int D  = msa_pkg::QUEUE_DEPTH;
    localparam int PB = $clog2(D);

    logic [WIDTH-1:0] mem [D];
    logic [PB-1:0]    wr_reg, rd_reg;
    logic [PB:0]      cnt_reg;
    logic             push, pop;

    assign in_ready  = cnt_reg != (PB+1)'(D);
    assign out_valid = cnt_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == PB'(D-1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == PB'(D-1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (PB+1)'(push) - (PB+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= in_data;
        end
    end

endmodule

FILE: src/msa_back.sv
// Back part: squares the determinants, runs a bit-serial floor square root
// and accumulates with saturation; emits the total on the last triangle.
// Depends on msa_pkg.
`timescale 1ns / 1ps

module msa_back #(
    parameter int COORD_BITS = 16,
    parameter int ACC_BITS   = 56
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [2*COORD_BITS+1:0] in_d1,
    input  logic [2*COORD_BITS+1:0] in_d2,
    input  logic [2*COORD_BITS+1:0] in_d3,
    input  logic                    in_last,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [ACC_BITS-1:0]     out_total,
    output logic                    out_sat
);
    localparam int AW = 2 * COORD_BITS + 2;   // determinant width
    localparam int HW = AW / 2;               // half of a determinant
    localparam int SW = 2 * AW + 2;           // sum of squares width
    localparam int RW = AW + 1;               // root width
    localparam int CW = $clog2(RW);
    localparam int XW = ((ACC_BITS > RW) ? ACC_BITS : RW) + 1;

    localparam logic [SW-1:0]       TOP_BIT = SW'(1) << (2 * (RW - 1));
    localparam logic [ACC_BITS-1:0] ACC_MAX = '1;

    msa_pkg::back_state_t st_reg, st_next;
    logic [AW-1:0]       d_reg [3];
    logic [1:0]          sq_idx_reg;
    logic                last_reg;
    logic [SW-1:0]       rem_reg;
    logic [SW-1:0]       res_reg;
    logic [SW-1:0]       bit_reg;
    logic [CW-1:0]       cnt_reg;
    logic [ACC_BITS-1:0] acc_reg;
    logic                sat_reg;
    logic                out_valid_reg, out_valid_next;
    logic [ACC_BITS-1:0] out_total_reg;
    logic                out_sat_reg;

    logic [AW-1:0]       d_cur;
    logic [HW-1:0]       d_hi, d_lo;
    logic [2*HW-1:0]     pp_hh, pp_hl, pp_ll;
    logic [SW-1:0]       sq_cur;
    logic [SW-1:0]       trial;
    logic [XW-1:0]       acc_sum;
    logic                clip;
    logic [ACC_BITS-1:0] acc_new;
    logic                sat_new;
    logic                take, fin, emit;

    always_comb
    begin
        case (sq_idx_reg)
            2'd0:    d_cur = d_reg[0];
            2'd1:    d_cur = d_reg[1];
            default: d_cur = d_reg[2];
        endcase
    end

    // square one determinant per cycle from half-width products
    assign d_hi   = d_cur[AW-1:HW];
    assign d_lo   = d_cur[HW-1:0];
    assign pp_hh  = (2*HW)'(d_hi) * (2*HW)'(d_hi);
    assign pp_hl  = (2*HW)'(d_hi) * (2*HW)'(d_lo);
    assign pp_ll  = (2*HW)'(d_lo) * (2*HW)'(d_lo);
    assign sq_cur = (SW'(pp_hh) << (2 * HW)) + (SW'(pp_hl) << (HW + 1)) + SW'(pp_ll);

    assign trial   = res_reg + bit_reg;
    assign acc_sum = XW'(acc_reg) + XW'(res_reg[RW-1:0]);
    assign clip    = acc_sum > XW'(ACC_MAX);
    assign acc_new = clip ? ACC_MAX : acc_sum[ACC_BITS-1:0];
    assign sat_new = sat_reg | clip;

    assign in_ready       = st_reg == msa_pkg::BK_IDLE;
    assign emit           = fin && last_reg;
    assign out_valid_next = emit || (out_valid_reg && !out_ready);

    assign out_valid = out_valid_reg;
    assign out_total = out_total_reg;
    assign out_sat   = out_sat_reg;

    always_comb
    begin
        st_next = st_reg;
        take    = 1'b0;
        fin     = 1'b0;
        unique case (st_reg)
            msa_pkg::BK_IDLE:
            begin
                take = in_valid;
                if (in_valid)
                begin
                    st_next = msa_pkg::BK_SQ;
                end
            end
            msa_pkg::BK_SQ:
            begin
                if (sq_idx_reg == 2'd2)
                begin
                    st_next = msa_pkg::BK_ROOT;
                end
            end
            msa_pkg::BK_ROOT:
            begin
                if (cnt_reg == CW'(RW - 1))
                begin
                    st_next = msa_pkg::BK_ACC;
                end
            end
            msa_pkg::BK_ACC:
            begin
                // hold a new total while the previous one still waits
                if (!(last_reg && out_valid_reg && !out_ready))
                begin
                    fin     = 1'b1;
                    st_next = msa_pkg::BK_IDLE;
                end
            end
            default: st_next = msa_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= msa_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
            out_total_reg <= '0;
            out_sat_reg   <= 1'b0;
            acc_reg       <= '0;
            sat_reg       <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
            if (fin)
            begin
                if (last_reg)
                begin
                    out_total_reg <= acc_new;
                    out_sat_reg   <= sat_new;
                    acc_reg       <= '0;
                    sat_reg       <= 1'b0;
                end
                else
                begin
                    acc_reg <= acc_new;
                    sat_reg <= sat_new;
                end
            end
        end
    end

    // root steps run RW times, one result bit each
    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            msa_pkg::BK_IDLE:
            begin
                if (take)
                begin
                    d_reg[0]   <= in_d1;
                    d_reg[1]   <= in_d2;
                    d_reg[2]   <= in_d3;
                    last_reg   <= in_last;
                    rem_reg    <= '0;
                    sq_idx_reg <= '0;
                    res_reg    <= '0;
                    bit_reg    <= TOP_BIT;
                    cnt_reg    <= '0;
                end
            end
            msa_pkg::BK_SQ:
            begin
                rem_reg    <= rem_reg + sq_cur;
                sq_idx_reg <= sq_idx_reg + 2'd1;
            end
            msa_pkg::BK_ROOT:
            begin
                if (rem_reg >= trial)
                begin
                    rem_reg <= rem_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg + 1'b1;
            end
            default: ;
        endcase
    end

endmodule

FILE: src/mesh_surface_area_unit.sv
// Top level of the mesh surface area unit: front, queue, back.
// Depends on msa_pkg, msa_front, msa_queue, msa_back.
`timescale 1ns / 1ps

// Each triangle beat adds the floor square root of its summed squared plane
// determinants, twice its area, into a saturating total; the beat with tlast
// emits that total on m_axis, with tuser high if it clipped, and clears it.
// The back part works on one triangle at a time: it takes it, squares the
// three determinants, runs 2*COORD_BITS+3 root steps at one bit per cycle
// and accumulates, and takes no new triangle until it is done. The front
// part and a two-entry queue hold up to four further triangles meanwhile.
// A total still waiting stalls only the next total.
module mesh_surface_area_unit #(
    parameter int COORD_BITS = 16,
    parameter int ACC_BITS   = 56
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // ax, ay, az, bx, by_coord, bz, cx, cy, cz
    input  logic [((9*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  logic                    s_axis_tlast,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // double_area_total
    output logic [((ACC_BITS+7)/8)*8-1:0] m_axis_tdata,
    // total_saturated
    output logic                    m_axis_tuser
);
    localparam int AW = 2 * COORD_BITS + 2;
    localparam int QW = 3 * AW + 1;
    localparam int OW = ((ACC_BITS + 7) / 8) * 8;

    logic          f_valid, f_ready, f_last;
    logic [AW-1:0] f_d1, f_d2, f_d3;
    logic          q_valid, q_ready;
    logic [QW-1:0] q_data;
    logic [ACC_BITS-1:0] total;

    msa_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_coords(s_axis_tdata[9*COORD_BITS-1:0]), .in_last(s_axis_tlast),
        .out_valid(f_valid), .out_ready(f_ready),
        .out_d1(f_d1), .out_d2(f_d2), .out_d3(f_d3), .out_last(f_last)
    );

    msa_queue #(.WIDTH(QW)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .in_valid(f_valid), .in_ready(f_ready),
        .in_data({f_last, f_d3, f_d2, f_d1}),
        .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
    );

    msa_back #(.COORD_BITS(COORD_BITS), .ACC_BITS(ACC_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .in_valid(q_valid), .in_ready(q_ready),
        .in_d1(q_data[AW-1:0]), .in_d2(q_data[2*AW-1:AW]),
        .in_d3(q_data[3*AW-1:2*AW]), .in_last(q_data[QW-1]),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_total(total), .out_sat(m_axis_tuser)
    );

    assign m_axis_tdata = OW'(total);

endmodule
